[src/fsf_pkg.sv]
// shared types and constants for the sensor frame deframer
package fsf_pkg;

  localparam int DATA_CAP    = 64;
  localparam int STORE_DEPTH = 64;
  localparam int POS_W       = $clog2(STORE_DEPTH);
  localparam int LEN_W       = 7;
  localparam int ADDR_W      = POS_W + 1;
  localparam int CFG_IDX_W   = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HEADER_FIRST   = 2'd0,
    CFG_HEADER_SECOND  = 2'd1,
    CFG_TRAILER_FIRST  = 2'd2,
    CFG_TRAILER_SECOND = 2'd3
  } cfg_index_t;

  typedef struct packed {
    logic [7:0]       control;
    logic [7:0]       command;
    logic [LEN_W-1:0] length;
  } frame_desc_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } store_wr_t;

endpackage

[src/fsf_parser.sv]
// front end: byte parser, checksum and payload writes into the current bank
module fsf_parser
  import fsf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  logic [7:0]           rx_byte,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data,
  output logic                 commit,
  output frame_desc_t          commit_desc,
  output store_wr_t            store_wr
);

  typedef enum logic [3:0] {
    PH_HUNT  = 4'd0,
    PH_HDR2  = 4'd1,
    PH_CTRL  = 4'd2,
    PH_CMD   = 4'd3,
    PH_LENHI = 4'd4,
    PH_LENLO = 4'd5,
    PH_DATA  = 4'd6,
    PH_SUM   = 4'd7,
    PH_END1  = 4'd8,
    PH_END2  = 4'd9
  } phase_t;

  phase_t           phase;
  logic [7:0]       header_first;
  logic [7:0]       header_second;
  logic [7:0]       trailer_first;
  logic [7:0]       trailer_second;
  logic [7:0]       held_control;
  logic [7:0]       held_command;
  logic [7:0]       length_hi;
  logic [LEN_W-1:0] length;
  logic [LEN_W-1:0] payload_count;
  logic [LEN_W-1:0] count_next;
  logic [7:0]       running_sum;
  logic [7:0]       sum_next;
  logic             wr_bank;

  assign sum_next   = running_sum + rx_byte;
  assign count_next = payload_count + LEN_W'(1);

  assign commit = accept && (phase == PH_END2) && (rx_byte == trailer_second);
  assign commit_desc.control = held_control;
  assign commit_desc.command = held_command;
  assign commit_desc.length  = length;

  assign store_wr.we   = accept && (phase == PH_DATA);
  assign store_wr.addr = {wr_bank, payload_count[POS_W-1:0]};
  assign store_wr.data = rx_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      header_first   <= 8'd83;
      header_second  <= 8'd89;
      trailer_first  <= 8'd84;
      trailer_second <= 8'd67;
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_HEADER_FIRST:   header_first   <= cfg_data;
        CFG_HEADER_SECOND:  header_second  <= cfg_data;
        CFG_TRAILER_FIRST:  trailer_first  <= cfg_data;
        CFG_TRAILER_SECOND: trailer_second <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HUNT;
      held_control  <= '0;
      held_command  <= '0;
      length_hi     <= '0;
      length        <= '0;
      payload_count <= '0;
      running_sum   <= '0;
      wr_bank       <= 1'b0;
    end else if (accept) begin
      unique case (phase)
        PH_HDR2: begin
          if (rx_byte == header_second) begin
            running_sum <= sum_next;
            phase       <= PH_CTRL;
          end else if (rx_byte == header_first) begin
            running_sum <= rx_byte;
            phase       <= PH_HDR2;
          end else begin
            phase <= PH_HUNT;
          end
        end
        PH_CTRL: begin
          held_control <= rx_byte;
          running_sum  <= sum_next;
          phase        <= PH_CMD;
        end
        PH_CMD: begin
          held_command <= rx_byte;
          running_sum  <= sum_next;
          phase        <= PH_LENHI;
        end
        PH_LENHI: begin
          length_hi   <= rx_byte;
          running_sum <= sum_next;
          phase       <= PH_LENLO;
        end
        PH_LENLO: begin
          running_sum   <= sum_next;
          payload_count <= '0;
          length        <= rx_byte[LEN_W-1:0];
          if (length_hi == 8'd0 && rx_byte == 8'd0) begin
            phase <= PH_SUM;
          end else if (length_hi == 8'd0 && rx_byte <= 8'(DATA_CAP)) begin
            phase <= PH_DATA;
          end else begin
            phase <= PH_HUNT;
          end
        end
        PH_DATA: begin
          payload_count <= count_next;
          running_sum   <= sum_next;
          if (count_next >= length) begin
            phase <= PH_SUM;
          end
        end
        PH_SUM: begin
          phase <= (running_sum == rx_byte) ? PH_END1 : PH_HUNT;
        end
        PH_END1: begin
          if (rx_byte == trailer_first) begin
            phase <= PH_END2;
          end else if (rx_byte == header_first) begin
            running_sum <= rx_byte;
            phase       <= PH_HDR2;
          end else begin
            phase <= PH_HUNT;
          end
        end
        PH_END2: begin
          // good frame: the next one goes into the other bank
          if (rx_byte == trailer_second) begin
            wr_bank <= ~wr_bank;
          end
          phase <= PH_HUNT;
        end
        default: begin
          if (rx_byte == header_first) begin
            running_sum <= rx_byte;
            phase       <= PH_HDR2;
          end else begin
            phase <= PH_HUNT;
          end
        end
      endcase
    end
  end

endmodule

[src/fsf_queue.sv]
// two-entry queue of finished frame descriptors between parser and emitter
module fsf_queue
  import fsf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push_desc,
  input  frame_desc_t push_data,
  input  logic        pop_desc,
  output frame_desc_t head,
  output logic        head_valid,
  output logic        q_full,
  output logic [1:0]  q_count
);

  frame_desc_t entries [2];
  logic        wr_ptr;
  logic        rd_ptr;

  assign head       = entries[rd_ptr];
  assign head_valid = (q_count != 2'd0);
  assign q_full     = (q_count == 2'd2);

  always_ff @(posedge clk) begin
    if (push_desc) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= 1'b0;
      rd_ptr  <= 1'b0;
      q_count <= 2'd0;
    end else begin
      if (push_desc) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop_desc) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push_desc && !pop_desc) begin
        q_count <= q_count + 2'd1;
      end else if (pop_desc && !push_desc) begin
        q_count <= q_count - 2'd1;
      end
    end
  end

endmodule

[src/fsf_emitter.sv]
// back end: two-bank payload memory and the result sequencer
module fsf_emitter
  import fsf_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  store_wr_t         store_wr,
  input  logic              desc_valid,
  input  frame_desc_t       desc,
  output logic              desc_pop,
  input  logic              pop,
  output logic              empty,
  output logic [7:0]        control_code,
  output logic [7:0]        command_code,
  output logic [LEN_W-1:0]  payload_length,
  output logic [7:0]        payload_byte,
  output logic [POS_W-1:0]  byte_position,
  output logic              last_of_frame
);

  typedef enum logic {
    ST_IDLE,
    ST_SHOW
  } state_t;

  logic [7:0]        mem [2*STORE_DEPTH];
  logic [7:0]        rd_data;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [POS_W-1:0]  pos_next;
  logic              rd_bank;
  logic [POS_W-1:0]  pos;
  state_t            state;

  assign pos_next = pos + POS_W'(1);

  assign control_code   = desc.control;
  assign command_code   = desc.command;
  assign payload_length = desc.length;
  assign payload_byte   = (desc.length == '0) ? 8'd0 : rd_data;
  assign byte_position  = pos;
  assign last_of_frame  = (desc.length == '0) ||
                          ({1'b0, pos} + LEN_W'(1) == desc.length);
  assign empty          = (state != ST_SHOW);

  // fetch the first byte on frame start, the next one on each beat taken
  assign rd_en   = ((state == ST_IDLE) && desc_valid) ||
                   ((state == ST_SHOW) && pop && !last_of_frame);
  assign rd_addr = {rd_bank, (state == ST_IDLE) ? '0 : pos_next};
  assign desc_pop = (state == ST_SHOW) && pop && last_of_frame;

  always_ff @(posedge clk) begin
    if (store_wr.we) begin
      mem[store_wr.addr] <= store_wr.data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      rd_bank <= 1'b0;
      pos     <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (desc_valid) begin
            pos   <= '0;
            state <= ST_SHOW;
          end
        end
        ST_SHOW: begin
          if (pop) begin
            if (last_of_frame) begin
              rd_bank <= ~rd_bank;
              state   <= ST_IDLE;
            end else begin
              pos <= pos_next;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

[src/sensor_frame_deframer.sv]
// Sensor frame deframer: sync bytes, control and command bytes, 16-bit big-endian
// length, payload, additive checksum and two end bytes; each good frame comes out
// as one result per payload byte (one result for an empty payload). The parser
// takes one byte per cycle while full is low; full rises only while two good
// frames are held, one of them still draining, since the payload memory has two
// banks of 64 bytes. Results leave at one per cycle while pop is held, from the
// registered read of that memory. With the back end idle, a frame's first result
// shows once the queue registers its descriptor and the emitter leaves idle; the
// emitter returns to idle between frames. No clearing pass is needed after reset.
module sensor_frame_deframer
  import fsf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  logic [7:0]           rx_byte,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data,
  output logic                 empty,
  input  logic                 pop,
  output logic [7:0]           control_code,
  output logic [7:0]           command_code,
  output logic [6:0]           payload_length,
  output logic [7:0]           payload_byte,
  output logic [5:0]           byte_position,
  output logic                 last_of_frame
);

  logic        accept;
  logic        commit;
  frame_desc_t commit_desc;
  store_wr_t   store_wr;
  frame_desc_t head;
  logic        head_valid;
  logic        desc_pop;
  logic [1:0]  q_count;

  assign accept = push && !full;

  fsf_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .rx_byte     (rx_byte),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .commit      (commit),
    .commit_desc (commit_desc),
    .store_wr    (store_wr)
  );

  fsf_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_desc  (commit),
    .push_data  (commit_desc),
    .pop_desc   (desc_pop),
    .head       (head),
    .head_valid (head_valid),
    .q_full     (full),
    .q_count    (q_count)
  );

  fsf_emitter u_emitter (
    .clk            (clk),
    .rst            (rst),
    .store_wr       (store_wr),
    .desc_valid     (head_valid),
    .desc           (head),
    .desc_pop       (desc_pop),
    .pop            (pop),
    .empty          (empty),
    .control_code   (control_code),
    .command_code   (command_code),
    .payload_length (payload_length),
    .payload_byte   (payload_byte),
    .byte_position  (byte_position),
    .last_of_frame  (last_of_frame)
  );

`ifndef SYNTHESIS
  // a result on the ports always belongs to a held frame
  a_result_has_frame: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (q_count != 2'd0))
    else $error("result shown with no frame held");

  // an empty payload gives exactly one result at position zero
  a_empty_payload: assert property (@(posedge clk) disable iff (rst)
    (!empty && payload_length == 7'd0) |-> (last_of_frame && byte_position == 6'd0))
    else $error("empty payload result malformed");

  // inside a frame the next beat follows directly at the next position
  a_next_position: assert property (@(posedge clk) disable iff (rst)
    (pop && !empty && !last_of_frame) |=>
      (!empty && byte_position == 6'($past(byte_position) + 6'd1)))
    else $error("payload position did not advance by one");
`endif

endmodule

[tb/sensor_frame_deframer_test.sv]
// self-checking testbench for the sensor frame deframer
module sensor_frame_deframer_test;
  timeunit 1ns;
  timeprecision 1ps;
  import fsf_pkg::*;

  localparam int IDLE_LIMIT   = 4000;
  localparam int DRAIN_CYCLES = 8;

  typedef struct packed {
    logic [7:0]       control;
    logic [7:0]       command;
    logic [LEN_W-1:0] length;
    logic [7:0]       data;
    logic [POS_W-1:0] pos;
    logic             last;
  } beat_t;

  typedef enum logic [3:0] {
    P_HUNT, P_HDR2, P_CTRL, P_CMD, P_LENHI, P_LENLO, P_DATA, P_SUM, P_END1, P_END2
  } parse_phase_t;

  class frame_tracker;
    logic [7:0]   hdr_a, hdr_b, end_a, end_b;
    parse_phase_t phase;
    logic [7:0]   ctrl, cmd, sum;
    logic [15:0]  dlen;
    int           count;
    logic [7:0]   store [STORE_DEPTH];
    beat_t        frame_beats_due [$];
    int           fails;

    function new();
      hdr_a = 8'd83;
      hdr_b = 8'd89;
      end_a = 8'd84;
      end_b = 8'd67;
      phase = P_HUNT;
      ctrl  = '0;
      cmd   = '0;
      sum   = '0;
      dlen  = '0;
      count = 0;
      fails = 0;
    endfunction

    function void set_reg(cfg_index_t idx, logic [7:0] v);
      case (idx)
        CFG_HEADER_FIRST:   hdr_a = v;
        CFG_HEADER_SECOND:  hdr_b = v;
        CFG_TRAILER_FIRST:  end_a = v;
        CFG_TRAILER_SECOND: end_b = v;
        default: ;
      endcase
    endfunction

    function void accept_byte(logic [7:0] b);
      beat_t bt;
      int    n;
      case (phase)
        P_HDR2: begin
          if (b == hdr_b) begin
            sum += b;
            phase = P_CTRL;
          end else if (b == hdr_a) begin
            sum = b;
            phase = P_HDR2;
          end else begin
            phase = P_HUNT;
          end
        end
        P_CTRL: begin
          ctrl = b;
          sum += b;
          phase = P_CMD;
        end
        P_CMD: begin
          cmd = b;
          sum += b;
          phase = P_LENHI;
        end
        P_LENHI: begin
          dlen = {b, 8'h00};
          sum += b;
          phase = P_LENLO;
        end
        P_LENLO: begin
          dlen = {dlen[15:8], b};
          sum += b;
          count = 0;
          if (dlen == 0) phase = P_SUM;
          else if (dlen <= DATA_CAP) phase = P_DATA;
          else phase = P_HUNT;
        end
        P_DATA: begin
          if (count >= DATA_CAP) begin
            phase = P_HUNT;
          end else begin
            store[count] = b;
            count++;
            sum += b;
            if (count >= dlen) phase = P_SUM;
          end
        end
        P_SUM: phase = (sum == b) ? P_END1 : P_HUNT;
        P_END1: begin
          if (b == end_a) begin
            phase = P_END2;
          end else if (b == hdr_a) begin
            sum = b;
            phase = P_HDR2;
          end else begin
            phase = P_HUNT;
          end
        end
        P_END2: begin
          if (b == end_b) begin
            n = (dlen == 0) ? 1 : int'(dlen);
            for (int k = 0; k < n; k++) begin
              bt.control = ctrl;
              bt.command = cmd;
              bt.length  = dlen[LEN_W-1:0];
              bt.data    = (dlen == 0) ? 8'h00 : store[k];
              bt.pos     = k[POS_W-1:0];
              bt.last    = (k == n - 1);
              frame_beats_due.push_back(bt);
            end
          end
          phase = P_HUNT;
        end
        default: begin
          if (b == hdr_a) begin
            sum = b;
            phase = P_HDR2;
          end else begin
            phase = P_HUNT;
          end
        end
      endcase
    endfunction

    function void match(string name, int want, int got);
      if (want != got) begin
        $error("%s expected %0d got %0d", name, want, got);
        fails++;
      end
    endfunction

    function void check_beat(beat_t got);
      beat_t want;
      if (frame_beats_due.size() == 0) begin
        $error("result beat with nothing expected");
        fails++;
        return;
      end
      want = frame_beats_due.pop_front();
      match("control_code", want.control, got.control);
      match("command_code", want.command, got.command);
      match("payload_length", want.length, got.length);
      match("payload_byte", want.data, got.data);
      match("byte_position", want.pos, got.pos);
      match("last_of_frame", want.last, got.last);
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 push;
  logic                 full;
  logic [7:0]           rx_byte;
  logic                 cfg_we;
  cfg_index_t           cfg_index;
  logic [7:0]           cfg_data;
  logic                 empty;
  logic                 pop;
  logic [7:0]           control_code;
  logic [7:0]           command_code;
  logic [6:0]           payload_length;
  logic [7:0]           payload_byte;
  logic [5:0]           byte_position;
  logic                 last_of_frame;

  frame_tracker board;
  logic [7:0]   frame_q [$];
  bit           in_calm;
  bit           out_calm;
  bit           long_frame_sent;
  int           idle_cycles;

  sensor_frame_deframer u_dut (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .rx_byte        (rx_byte),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .empty          (empty),
    .pop            (pop),
    .control_code   (control_code),
    .command_code   (command_code),
    .payload_length (payload_length),
    .payload_byte   (payload_byte),
    .byte_position  (byte_position),
    .last_of_frame  (last_of_frame)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // no beat on either side for too long means the block is stuck
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // frame under the current sync and end bytes, well-formed up to the length cap
  function automatic void make_frame(logic [7:0] ctrl, logic [7:0] cmd, logic [15:0] len);
    logic [7:0] sum;
    frame_q = {};
    frame_q.push_back(board.hdr_a);
    frame_q.push_back(board.hdr_b);
    frame_q.push_back(ctrl);
    frame_q.push_back(cmd);
    frame_q.push_back(len[15:8]);
    frame_q.push_back(len[7:0]);
    if (len <= DATA_CAP) repeat (int'(len)) frame_q.push_back(8'($urandom));
    sum = '0;
    foreach (frame_q[i]) sum += frame_q[i];
    frame_q.push_back(sum);
    frame_q.push_back(board.end_a);
    frame_q.push_back(board.end_b);
  endfunction

  // entered and left at a falling edge
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = in_calm ? 0 : $urandom_range(0, 12);
    if ($urandom_range(0, 39) == 0) in_calm = !in_calm;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    push    <= 1'b1;
    rx_byte <= b;
    @(posedge clk);
    while (full) @(posedge clk);
    board.accept_byte(b);
    @(negedge clk);
  endtask

  task automatic send_frame_q();
    foreach (frame_q[i]) send_byte(frame_q[i]);
  endtask

  // wait until every expected beat is out and the parser has gone quiet
  task automatic settle();
    push <= 1'b0;
    while (board.frame_beats_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic apply_settings(input logic [7:0] vals [4]);
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= cfg_index_t'(i);
      cfg_data  <= vals[i];
      @(negedge clk);
      board.set_reg(cfg_index_t'(i), vals[i]);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic directed_checks();
    make_frame(8'hFF, 8'h00, 16'd0);
    send_frame_q();
    // noise while hunting, then a wrong second sync byte
    send_byte(8'hAA);
    send_byte(board.hdr_a);
    send_byte(~board.hdr_a);
    // extra first sync byte restarts the frame
    send_byte(board.hdr_a);
    make_frame(8'h00, 8'hFF, 16'd1);
    send_frame_q();
    // frame cut after its checksum, restarted by the next header
    make_frame(8'($urandom), 8'($urandom), 16'd2);
    frame_q = frame_q[0:8];
    send_frame_q();
    make_frame(8'($urandom), 8'($urandom), 16'd0);
    send_frame_q();
    // bad checksum
    make_frame(8'($urandom), 8'($urandom), 16'd0);
    frame_q[6] ^= 8'h01;
    frame_q = frame_q[0:6];
    send_frame_q();
    // length just above the cap and the largest length
    make_frame(8'($urandom), 8'($urandom), 16'(DATA_CAP + 1));
    frame_q = frame_q[0:5];
    send_frame_q();
    make_frame(8'($urandom), 8'($urandom), 16'hFFFF);
    frame_q = frame_q[0:5];
    send_frame_q();
    // wrong last end byte
    make_frame(8'($urandom), 8'($urandom), 16'd0);
    frame_q[8] ^= 8'h80;
    send_frame_q();
  endtask

  task automatic random_traffic(input int budget);
    int sent;
    int kind;
    int len;
    int r;
    int cut;
    sent = 0;
    while (sent < budget) begin
      r = $urandom_range(0, 29);
      if (!long_frame_sent) len = DATA_CAP;
      else if (r == 0) len = DATA_CAP;
      else if (r < 5) len = $urandom_range(9, DATA_CAP);
      else len = $urandom_range(0, 8);
      long_frame_sent = 1'b1;
      make_frame(8'($urandom), 8'($urandom), 16'(len));
      kind = $urandom_range(0, 19);
      case (kind)
        0, 1: frame_q[len + 6] ^= 8'($urandom_range(1, 255));
        2:    frame_q[len + 7] ^= 8'($urandom_range(1, 255));
        3:    frame_q[len + 8] ^= 8'($urandom_range(1, 255));
        4: begin
          make_frame(8'($urandom), 8'($urandom), 16'($urandom_range(DATA_CAP + 1, 16'hFFFF)));
          frame_q = frame_q[0:5];
        end
        5: begin
          cut = $urandom_range(1, frame_q.size() - 1);
          frame_q = frame_q[0:cut-1];
        end
        6: begin
          frame_q = {};
          repeat ($urandom_range(1, 4)) frame_q.push_back(8'($urandom));
        end
        default: ;
      endcase
      sent += frame_q.size();
      send_frame_q();
    end
  endtask

  initial begin : result_side
    int    gap;
    beat_t got;
    pop = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      gap = out_calm ? 0 : $urandom_range(0, 12);
      if ($urandom_range(0, 39) == 0) out_calm = !out_calm;
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
      while (empty) @(posedge clk);
      got.control = control_code;
      got.command = command_code;
      got.length  = payload_length;
      got.data    = payload_byte;
      got.pos     = byte_position;
      got.last    = last_of_frame;
      board.check_beat(got);
      @(negedge clk);
    end
  end

  initial begin
    board     = new();
    rst       = 1'b1;
    push      = 1'b0;
    rx_byte   = 8'h00;
    cfg_we    = 1'b0;
    cfg_index = CFG_HEADER_FIRST;
    cfg_data  = 8'h00;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    directed_checks();
    random_traffic(30);
    settle();
    apply_settings('{8'h00, 8'h00, 8'h00, 8'h00});
    random_traffic(30);
    settle();
    apply_settings('{8'hFF, 8'hFF, 8'hFF, 8'hFF});
    random_traffic(30);
    settle();
    apply_settings('{8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom)});
    random_traffic(30);
    settle();
    apply_settings('{8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom)});
    random_traffic(30);

    settle();
    repeat (12) @(negedge clk);
    if (board.fails == 0 && board.frame_beats_due.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[files.f]
src/fsf_pkg.sv
src/fsf_parser.sv
src/fsf_queue.sv
src/fsf_emitter.sv
src/sensor_frame_deframer.sv
tb/sensor_frame_deframer_test.sv
